// ----- rtl/oal_pkg.sv -----
// Ordered array list: shared types and codes.
// No dependencies; imported by both channel interfaces, the list memory and the top level.
package oal_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 2;
	localparam int FIDX_W  = 4;
	localparam int LEN_W   = 5;

	localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_STEP,
		S_DONE
	} state_t;

endpackage

// ----- rtl/oal_cmd_if.sv -----
// Command channel of the ordered array list: valid/ready plus one command.
// Depends on oal_pkg.
interface oal_cmd_if;
	import oal_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// ----- rtl/oal_rsp_if.sv -----
// Response channel of the ordered array list: valid/ready plus one result.
// Depends on oal_pkg.
interface oal_rsp_if;
	import oal_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [FIDX_W-1:0] found_index;
	logic [LEN_W-1:0]  length;

	modport source (output valid, output status, output found_index, output length,
		input ready);
	modport sink   (input valid, input status, input found_index, input length,
		output ready);
endinterface

// ----- rtl/oal_mem.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on oal_pkg for the data width. No reset: contents undefined until written.
module oal_mem #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(DEPTH)-1:0]           waddr,
	input  logic [oal_pkg::DATA_W-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]           raddr,
	output logic [oal_pkg::DATA_W-1:0]         rdata
);
	import oal_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ordered_array_list_top.sv -----
// Ordered array list top level: command decode, sequencer and result register.
// Depends on oal_pkg, oal_cmd_if, oal_rsp_if and oal_mem.
//
//   channel | dir | beat carries
//   --------+-----+------------------------------------------
//   cmd     | in  | op, value (signed 32b), position (1-based)
//   rsp     | out | status, found_index, length
//
// One command at a time. Every entry moved or compared takes an S_SCAN
// state (read issue) and then an S_STEP state (use of the registered read
// data) on the memory read port. Find stops at the first match or at the
// end of the list; insert and delete shift the entries behind the position;
// refused commands and op 3 go straight to S_DONE.
// Reset clears the count and control only; stored entries need no clearing.
// A result waits in its register while rsp is stalled; the next command is
// accepted meanwhile and only its result hand-off waits.
module ordered_array_list_top #(
	parameter int CAPACITY = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	oal_cmd_if.sink   cmd,
	oal_rsp_if.source rsp
);
	import oal_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);          // holds 0..CAPACITY
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1; // compare width

	state_t state_q, state_d;

	// Command held for the length of its sequence.
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;

	// Sequencer datapath.
	logic [CW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     count_q, count_d;
	logic [STAT_W-1:0] st_q, st_d;
	logic [FIDX_W-1:0] fi_q, fi_d;

	// Result register.
	logic              rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [FIDX_W-1:0] rsp_fidx_q;
	logic [LEN_W-1:0]  rsp_len_q;
	logic              load_out;

	// Memory port.
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	logic          cmd_fire;
	logic [PW-1:0] pos_in_w, pos_w, cnt_w, idx_w;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign pos_in_w = PW'(cmd.position);
	assign pos_w    = PW'(pos_q);
	assign cnt_w    = PW'(count_q);
	assign idx_w    = PW'(idx_q);

	oal_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, datapath updates and memory port control.
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		st_d      = st_q;
		fi_d      = fi_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		load_out  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					st_d  = ST_OK;
					fi_d  = '0;
					idx_d = '0;
					case (cmd.op)
						OP_FIND: begin
							state_d = S_SCAN;
						end
						OP_INSERT: begin
							if (cnt_w >= PW'(CAPACITY)) begin
								st_d    = ST_FULL;
								state_d = S_DONE;
							end else if (pos_in_w == '0 || pos_in_w > cnt_w + PW'(1)) begin
								st_d    = ST_BADPOS;
								state_d = S_DONE;
							end else begin
								// shift from the tail down to the insert slot
								idx_d   = count_q;
								state_d = S_SCAN;
							end
						end
						OP_DELETE: begin
							if (pos_in_w == '0 || pos_in_w > cnt_w) begin
								st_d    = ST_BADPOS;
								state_d = S_DONE;
							end else begin
								// pull entries from just past the hole upward
								idx_d   = CW'(cmd.position);
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			S_SCAN: begin
				case (op_q)
					OP_FIND: begin
						if (idx_w < cnt_w) begin
							mem_raddr = AW'(idx_q);
							state_d   = S_STEP;
						end else begin
							st_d    = ST_NOTFOUND;
							state_d = S_DONE;
						end
					end
					OP_INSERT: begin
						if (idx_w >= pos_w) begin
							mem_raddr = AW'(idx_q - CW'(1));
							state_d   = S_STEP;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = AW'(pos_w - PW'(1));
							mem_wdata = val_q;
							count_d   = count_q + CW'(1);
							state_d   = S_DONE;
						end
					end
					OP_DELETE: begin
						if (idx_w < cnt_w) begin
							mem_raddr = AW'(idx_q);
							state_d   = S_STEP;
						end else begin
							count_d = count_q - CW'(1);
							state_d = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_STEP: begin
				case (op_q)
					OP_FIND: begin
						if (mem_rdata == val_q) begin
							fi_d    = FIDX_W'(idx_q);
							state_d = S_DONE;
						end else begin
							idx_d   = idx_q + CW'(1);
							state_d = S_SCAN;
						end
					end
					OP_INSERT: begin
						mem_we    = 1'b1;
						mem_waddr = AW'(idx_q);
						idx_d     = idx_q - CW'(1);
						state_d   = S_SCAN;
					end
					OP_DELETE: begin
						mem_we    = 1'b1;
						mem_waddr = AW'(idx_q - CW'(1));
						idx_d     = idx_q + CW'(1);
						state_d   = S_SCAN;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		st_q  <= st_d;
		fi_q  <= fi_d;
		if (cmd_fire) begin
			op_q  <= cmd.op;
			val_q <= cmd.value;
			pos_q <= cmd.position;
		end
		if (load_out) begin
			rsp_status_q <= st_q;
			rsp_fidx_q   <= fi_q;
			rsp_len_q    <= LEN_W'(count_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_index = rsp_fidx_q;
	assign rsp.length      = rsp_len_q;

	// Count never passes capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(count_q) <= PW'(CAPACITY))
		else $error("count above capacity");

	// Count moves by at most one per command.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + CW'(1) ||
		                      count_q == $past(count_q) - CW'(1)))
		else $error("count jumped");

	// Writes land inside the live list or one past its end (insert).
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> PW'(mem_waddr) <= cnt_w)
		else $error("write outside list");

	// An accepted command always starts a sequence.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> state_q != S_IDLE)
		else $error("accepted command dropped");

	// A result is only loaded once the previous one has left or is leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!rsp_valid_q || rsp.ready))
		else $error("result overwritten");

endmodule
